[rtl/msrsg_pkg.sv]
package msrsg_pkg;

    // Fixed field widths
    localparam int REQ_W     = 3;
    localparam int MODE_W    = 3;
    localparam int DIR_W     = 2;
    localparam int CNT_W     = 8;
    localparam int THR_W     = 12;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;

    // Shift-add multiply and restoring divide run one bit per cycle over CFG_W bits
    localparam int STEP_W = $clog2(CFG_W);

    typedef logic [REQ_W-1:0]     req_t;
    typedef logic [MODE_W-1:0]    mode_t;
    typedef logic [DIR_W-1:0]     dir_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    typedef logic [CFG_W-1:0]     cfg_data_t;

    // Request codes
    localparam req_t REQ_TICK = 3'd0;
    localparam req_t REQ_UP   = 3'd1;
    localparam req_t REQ_DN   = 3'd2;
    localparam req_t REQ_SOFT = 3'd3;
    localparam req_t REQ_HARD = 3'd4;

    // Motor modes
    localparam mode_t M_STOPPED = 3'd0;
    localparam mode_t M_RAMP_UP = 3'd1;
    localparam mode_t M_RUN_UP  = 3'd2;
    localparam mode_t M_RAMP_DN = 3'd3;
    localparam mode_t M_RUN_DN  = 3'd4;
    localparam mode_t M_STOP_UP = 3'd5;
    localparam mode_t M_STOP_DN = 3'd6;

    // Directions
    localparam dir_t DIR_NONE = 2'd0;
    localparam dir_t DIR_UP   = 2'd1;
    localparam dir_t DIR_DN   = 2'd2;

    // Configuration register indexes
    localparam cfg_idx_t REG_MAX_DUTY = 3'd0;
    localparam cfg_idx_t REG_RAMP_MS  = 3'd1;
    localparam cfg_idx_t REG_INRUSH   = 3'd2;
    localparam cfg_idx_t REG_STALL_TH = 3'd3;
    localparam cfg_idx_t REG_CONFIRM  = 3'd4;

    // Configuration reset values
    localparam logic [CFG_W-1:0] RST_MAX_DUTY = 16'd8191;
    localparam logic [CFG_W-1:0] RST_RAMP_MS  = 16'd500;
    localparam logic [CFG_W-1:0] RST_INRUSH   = 16'd300;
    localparam logic [THR_W-1:0] RST_STALL_TH = 12'd2000;
    localparam logic [CNT_W-1:0] RST_CONFIRM  = 8'd3;

endpackage

[rtl/msrsg_if.sv]
interface msrsg_in_if #(
    parameter int TIME_BITS   = 32,
    parameter int SAMPLE_BITS = 12
);
    import msrsg_pkg::*;

    logic                   valid;
    logic                   ready;
    req_t                   req_type;
    logic [TIME_BITS-1:0]   now_ms;
    logic [SAMPLE_BITS-1:0] current_sample;
    logic                   sample_valid;

    modport source (output valid, output req_type, output now_ms,
                    output current_sample, output sample_valid, input ready);
    modport sink   (input valid, input req_type, input now_ms,
                    input current_sample, input sample_valid, output ready);
endinterface

interface msrsg_out_if #(
    parameter int DUTY_BITS = 16
);
    import msrsg_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [DUTY_BITS-1:0] duty_up;
    logic [DUTY_BITS-1:0] duty_down;
    logic                 enable_up;
    logic                 enable_down;
    mode_t                motor_mode;
    logic                 stall_event;
    logic                 stalled_flag;
    logic                 running;

    modport source (output valid, output duty_up, output duty_down, output enable_up,
                    output enable_down, output motor_mode, output stall_event,
                    output stalled_flag, output running, input ready);
    modport sink   (input valid, input duty_up, input duty_down, input enable_up,
                    input enable_down, input motor_mode, input stall_event,
                    input stalled_flag, input running, output ready);
endinterface

[rtl/motor_soft_ramp_stall_guard_core.sv]
// Flow: an accepted input transaction is captured, then passes the CALC and FIN phases
//   for commands, idle ticks and ticks whose ramp is complete; a tick inside a ramp also
//   runs a bit-serial shift-add multiply and restoring divide (MUL, DIV) to form the duty.
// FIN holds while the output is stalled, and a new transaction is taken only when idle;
//   the single multiply/divide shift register serves one transaction at a time.
// Reset: rst_n clears the motor state to stopped and loads the register defaults.
module motor_soft_ramp_stall_guard_core #(
    parameter int DUTY_BITS   = 16,
    parameter int TIME_BITS   = 32,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                 clk,
    input  logic                 rst_n,
    msrsg_in_if.sink             in_ch,
    msrsg_out_if.source          out_ch,
    input  logic                 cfg_we,
    input  msrsg_pkg::cfg_idx_t  cfg_idx,
    input  msrsg_pkg::cfg_data_t cfg_data
);
    import msrsg_pkg::*;

    localparam int CMP_W = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_CALC = 3'd1;
    localparam logic [2:0] PH_MUL  = 3'd2;
    localparam logic [2:0] PH_DIV  = 3'd3;
    localparam logic [2:0] PH_FIN  = 3'd4;

    // Configuration registers
    logic [CFG_W-1:0] max_duty_reg;
    logic [CFG_W-1:0] ramp_ms_reg;
    logic [CFG_W-1:0] inrush_reg;
    logic [THR_W-1:0] stall_th_reg;
    logic [CNT_W-1:0] confirm_reg;

    // Sequencer and captured transaction
    logic [2:0]             phase_reg, phase_next;
    logic [STEP_W-1:0]      step_reg;
    logic [2*CFG_W-1:0]     acc_reg, acc_next;
    req_t                   req_reg;
    logic [TIME_BITS-1:0]   now_reg;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic                   svalid_reg;

    // Motor state
    mode_t                mode_reg, mode_next;
    dir_t                 dir_reg, dir_next;
    logic [TIME_BITS-1:0] ramp_start_reg, ramp_start_next;
    logic [TIME_BITS-1:0] run_start_reg, run_start_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 stalled_reg, stalled_next;
    logic [DUTY_BITS-1:0] up_duty_reg, up_duty_next;
    logic [DUTY_BITS-1:0] dn_duty_reg, dn_duty_next;
    logic [1:0]           en_reg, en_next;
    logic                 stall_ev_reg, stall_ev_next;
    logic                 out_valid_reg;

    logic                 in_fire;
    logic                 commit;
    logic [TIME_BITS-1:0] elapsed;
    logic [TIME_BITS-1:0] run_elapsed;
    logic                 ramp_done;
    logic                 in_ramp_mode;
    logic                 need_div;
    logic [CFG_W-1:0]     part;
    logic [CFG_W-1:0]     ramp_duty;
    logic [CFG_W-1:0]     stop_duty;
    logic [CFG_W:0]       mul_sum;
    logic [CFG_W:0]       div_trial;
    logic                 div_ge;
    logic [CFG_W:0]       div_diff;
    logic [CNT_W-1:0]     cnt_tmp;
    logic                 over_th;

    assign in_fire     = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (phase_reg == PH_IDLE);
    assign commit      = (phase_reg == PH_FIN) && (!out_valid_reg || out_ch.ready);

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_duty_reg <= RST_MAX_DUTY;
            ramp_ms_reg  <= RST_RAMP_MS;
            inrush_reg   <= RST_INRUSH;
            stall_th_reg <= RST_STALL_TH;
            confirm_reg  <= RST_CONFIRM;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                REG_MAX_DUTY: max_duty_reg <= cfg_data;
                REG_RAMP_MS:  ramp_ms_reg  <= cfg_data;
                REG_INRUSH:   inrush_reg   <= cfg_data;
                REG_STALL_TH: stall_th_reg <= cfg_data[THR_W-1:0];
                REG_CONFIRM:  confirm_reg  <= cfg_data[CNT_W-1:0];
                default:      ;
            endcase
        end
    end

    // Capture the input transaction
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            req_reg    <= in_ch.req_type;
            now_reg    <= in_ch.now_ms;
            sample_reg <= in_ch.current_sample;
            svalid_reg <= in_ch.sample_valid;
        end
    end

    // Ramp timing
    assign elapsed      = now_reg - ramp_start_reg;
    assign run_elapsed  = now_reg - run_start_reg;
    assign ramp_done    = (elapsed >= TIME_BITS'(ramp_ms_reg));
    assign in_ramp_mode = (mode_reg == M_RAMP_UP) || (mode_reg == M_RAMP_DN) ||
                          (mode_reg == M_STOP_UP) || (mode_reg == M_STOP_DN);
    assign need_div     = (req_reg == REQ_TICK) && in_ramp_mode && !ramp_done;

    // One multiply step: add max_duty on the low bit, shift right
    assign mul_sum = {1'b0, acc_reg[2*CFG_W-1:CFG_W]} +
                     (acc_reg[0] ? {1'b0, max_duty_reg} : {(CFG_W+1){1'b0}});

    // One divide step: shift in a dividend bit, subtract ramp_ms if it fits
    assign div_trial = {acc_reg[2*CFG_W-1:CFG_W], acc_reg[CFG_W-1]};
    assign div_ge    = (div_trial >= {1'b0, ramp_ms_reg});
    assign div_diff  = div_trial - {1'b0, ramp_ms_reg};

    // Sequencer
    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        case (phase_reg)
            PH_IDLE:
            begin
                if (in_fire)
                    phase_next = PH_CALC;
            end
            PH_CALC:
            begin
                acc_next = {{CFG_W{1'b0}}, elapsed[CFG_W-1:0]};
                phase_next = need_div ? PH_MUL : PH_FIN;
            end
            PH_MUL:
            begin
                acc_next = {mul_sum, acc_reg[CFG_W-1:1]};
                if (step_reg == STEP_W'(CFG_W - 1))
                    phase_next = PH_DIV;
            end
            PH_DIV:
            begin
                acc_next = {(div_ge ? div_diff[CFG_W-1:0] : div_trial[CFG_W-1:0]),
                            acc_reg[CFG_W-2:0], div_ge};
                if (step_reg == STEP_W'(CFG_W - 1))
                    phase_next = PH_FIN;
            end
            PH_FIN:
            begin
                if (commit)
                    phase_next = PH_IDLE;
            end
            default:
                phase_next = PH_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            if ((phase_reg == PH_MUL) || (phase_reg == PH_DIV))
                step_reg <= step_reg + 1'b1;
            else
                step_reg <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    // Duties from the quotient
    assign part      = acc_reg[CFG_W-1:0];
    assign ramp_duty = ramp_done ? max_duty_reg : part;
    assign stop_duty = ramp_done ? {CFG_W{1'b0}} : (max_duty_reg - part);
    assign over_th   = (CMP_W'(sample_reg) > CMP_W'(stall_th_reg));

    // Next motor state for the captured transaction
    always_comb
    begin
        mode_next       = mode_reg;
        dir_next        = dir_reg;
        ramp_start_next = ramp_start_reg;
        run_start_next  = run_start_reg;
        cnt_next        = cnt_reg;
        stalled_next    = stalled_reg;
        up_duty_next    = up_duty_reg;
        dn_duty_next    = dn_duty_reg;
        en_next         = en_reg;
        stall_ev_next   = 1'b0;
        cnt_tmp         = '0;
        case (req_reg)
            REQ_TICK:
            begin
                case (mode_reg)
                    M_RAMP_UP, M_RAMP_DN:
                    begin
                        if (dir_reg == DIR_UP)
                            up_duty_next = DUTY_BITS'(ramp_duty);
                        else
                            dn_duty_next = DUTY_BITS'(ramp_duty);
                        if (ramp_duty >= max_duty_reg)
                        begin
                            mode_next      = (dir_reg == DIR_UP) ? M_RUN_UP : M_RUN_DN;
                            run_start_next = now_reg;
                            cnt_next       = '0;
                        end
                    end
                    M_RUN_UP, M_RUN_DN:
                    begin
                        if ((run_elapsed > TIME_BITS'(inrush_reg)) && svalid_reg)
                        begin
                            if (over_th)
                                cnt_tmp = (cnt_reg == {CNT_W{1'b1}}) ? cnt_reg
                                                                    : cnt_reg + 1'b1;
                            else
                                cnt_tmp = '0;
                            cnt_next = cnt_tmp;
                            if (cnt_tmp >= confirm_reg)
                            begin
                                up_duty_next  = '0;
                                dn_duty_next  = '0;
                                en_next       = 2'b00;
                                dir_next      = DIR_NONE;
                                mode_next     = M_STOPPED;
                                stalled_next  = 1'b1;
                                stall_ev_next = 1'b1;
                                cnt_next      = '0;
                            end
                        end
                    end
                    M_STOP_UP, M_STOP_DN:
                    begin
                        if (dir_reg == DIR_UP)
                            up_duty_next = DUTY_BITS'(stop_duty);
                        else
                            dn_duty_next = DUTY_BITS'(stop_duty);
                        if (stop_duty == {CFG_W{1'b0}})
                        begin
                            en_next   = 2'b00;
                            mode_next = M_STOPPED;
                            dir_next  = DIR_NONE;
                            cnt_next  = '0;
                        end
                    end
                    default:
                        cnt_next = '0;
                endcase
            end
            REQ_UP:
            begin
                stalled_next = 1'b0;
                if ((mode_reg != M_RAMP_UP) && (mode_reg != M_RUN_UP))
                begin
                    en_next         = 2'b01;
                    up_duty_next    = '0;
                    dn_duty_next    = '0;
                    dir_next        = DIR_UP;
                    ramp_start_next = now_reg;
                    mode_next       = M_RAMP_UP;
                end
            end
            REQ_DN:
            begin
                stalled_next = 1'b0;
                if ((mode_reg != M_RAMP_DN) && (mode_reg != M_RUN_DN))
                begin
                    en_next         = 2'b10;
                    up_duty_next    = '0;
                    dn_duty_next    = '0;
                    dir_next        = DIR_DN;
                    ramp_start_next = now_reg;
                    mode_next       = M_RAMP_DN;
                end
            end
            REQ_SOFT:
            begin
                if ((mode_reg == M_RAMP_UP) || (mode_reg == M_RUN_UP))
                begin
                    mode_next       = M_STOP_UP;
                    ramp_start_next = now_reg;
                end
                else if ((mode_reg == M_RAMP_DN) || (mode_reg == M_RUN_DN))
                begin
                    mode_next       = M_STOP_DN;
                    ramp_start_next = now_reg;
                end
            end
            REQ_HARD:
            begin
                up_duty_next = '0;
                dn_duty_next = '0;
                en_next      = 2'b00;
                dir_next     = DIR_NONE;
                mode_next    = M_STOPPED;
                stalled_next = 1'b1;
            end
            default: ;
        endcase
    end

    // Commit the state; it doubles as the result payload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= M_STOPPED;
            dir_reg        <= DIR_NONE;
            ramp_start_reg <= '0;
            run_start_reg  <= '0;
            cnt_reg        <= '0;
            stalled_reg    <= 1'b0;
            up_duty_reg    <= '0;
            dn_duty_reg    <= '0;
            en_reg         <= 2'b00;
            stall_ev_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (commit)
            begin
                mode_reg       <= mode_next;
                dir_reg        <= dir_next;
                ramp_start_reg <= ramp_start_next;
                run_start_reg  <= run_start_next;
                cnt_reg        <= cnt_next;
                stalled_reg    <= stalled_next;
                up_duty_reg    <= up_duty_next;
                dn_duty_reg    <= dn_duty_next;
                en_reg         <= en_next;
                stall_ev_reg   <= stall_ev_next;
                out_valid_reg  <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Drive the result transaction
    assign out_ch.valid        = out_valid_reg;
    assign out_ch.duty_up      = up_duty_reg;
    assign out_ch.duty_down    = dn_duty_reg;
    assign out_ch.enable_up    = en_reg[0];
    assign out_ch.enable_down  = en_reg[1];
    assign out_ch.motor_mode   = mode_reg;
    assign out_ch.stall_event  = stall_ev_reg;
    assign out_ch.stalled_flag = stalled_reg;
    assign out_ch.running      = (mode_reg == M_RUN_UP) || (mode_reg == M_RUN_DN);

    // Checks
    a_bridge_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(en_reg))
        else $error("both half-bridges enabled");

    a_stopped_disabled: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == M_STOPPED) |-> (en_reg == 2'b00))
        else $error("bridge enabled while stopped");

    a_stall_stops: assert property (@(posedge clk) disable iff (!rst_n)
        stall_ev_reg |-> ((mode_reg == M_STOPPED) && stalled_reg))
        else $error("stall event without stop");

    a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !commit |=> ($stable(mode_reg) && $stable(en_reg) && $stable(up_duty_reg)))
        else $error("motor state changed outside commit");

endmodule

[dv/tb_motor_soft_ramp_stall_guard_core.sv]
`timescale 1ns / 1ps

import msrsg_pkg::*;

// One request as presented on the input channel
typedef struct packed {
    req_t        req;
    logic [31:0] now;
    logic [11:0] sample;
    logic        sample_ok;
} motor_request_t;

// One status word as presented on the output channel
typedef struct packed {
    logic [15:0] duty_up;
    logic [15:0] duty_down;
    logic        enable_up;
    logic        enable_down;
    mode_t       motor_mode;
    logic        stall_event;
    logic        stalled_flag;
    logic        running;
} motor_status_t;

class motor_scoreboard;
    // register copies
    logic [15:0] max_duty;
    logic [15:0] ramp_ms;
    logic [15:0] inrush_ms;
    logic [11:0] stall_th;
    logic [7:0]  confirm_cnt;

    // motor state copies
    mode_t       mode;
    dir_t        dir;
    logic [31:0] ramp_t0;
    logic [31:0] run_t0;
    logic [7:0]  over_cnt;
    logic        stalled;
    logic [15:0] up_duty;
    logic [15:0] down_duty;
    logic [1:0]  bridge_en;

    motor_status_t status_q[$];
    int unsigned   mismatches;
    int unsigned   results_seen;

    function new();
        max_duty     = RST_MAX_DUTY;
        ramp_ms      = RST_RAMP_MS;
        inrush_ms    = RST_INRUSH;
        stall_th     = RST_STALL_TH;
        confirm_cnt  = RST_CONFIRM;
        mode         = M_STOPPED;
        dir          = DIR_NONE;
        ramp_t0      = '0;
        run_t0       = '0;
        over_cnt     = '0;
        stalled      = 1'b0;
        up_duty      = '0;
        down_duty    = '0;
        bridge_en    = '0;
        mismatches   = 0;
        results_seen = 0;
    endfunction

    function void set_register(cfg_idx_t idx, cfg_data_t data);
        case (idx)
            REG_MAX_DUTY: max_duty    = data;
            REG_RAMP_MS:  ramp_ms     = data;
            REG_INRUSH:   inrush_ms   = data;
            REG_STALL_TH: stall_th    = data[THR_W-1:0];
            REG_CONFIRM:  confirm_cnt = data[CNT_W-1:0];
            default:      ;
        endcase
    endfunction

    // Linear share of full duty after the given age; only called mid-ramp
    function logic [15:0] ramp_share(logic [31:0] age);
        logic [47:0] prod;
        prod = 48'(age) * 48'(max_duty);
        return 16'(prod / 48'(ramp_ms));
    endfunction

    // Apply a duty to the channel of the current direction
    function void set_duty(logic [15:0] duty);
        if (dir == DIR_UP)
            up_duty = duty;
        else
            down_duty = duty;
    endfunction

    function void halt();
        up_duty   = '0;
        down_duty = '0;
        bridge_en = '0;
        dir       = DIR_NONE;
        mode      = M_STOPPED;
        stalled   = 1'b1;
    endfunction

    function void start_motion(dir_t d, logic [31:0] t);
        stalled = 1'b0;
        if (d == DIR_UP && (mode == M_RAMP_UP || mode == M_RUN_UP))
            return;
        if (d == DIR_DN && (mode == M_RAMP_DN || mode == M_RUN_DN))
            return;
        bridge_en = (d == DIR_UP) ? 2'b01 : 2'b10;
        up_duty   = '0;
        down_duty = '0;
        dir       = d;
        ramp_t0   = t;
        mode      = (d == DIR_UP) ? M_RAMP_UP : M_RAMP_DN;
    endfunction

    // Advance the motor state for one accepted request and queue its status
    function void note_request(motor_request_t rq);
        logic [31:0]   ramp_age;
        logic [31:0]   run_age;
        logic [15:0]   duty;
        logic          stall_hit;
        motor_status_t st;
        stall_hit = 1'b0;
        ramp_age  = rq.now - ramp_t0;
        run_age   = rq.now - run_t0;
        case (rq.req)
            REQ_TICK:
            begin
                case (mode)
                    M_RAMP_UP, M_RAMP_DN:
                    begin
                        duty = (ramp_age >= 32'(ramp_ms)) ? max_duty : ramp_share(ramp_age);
                        set_duty(duty);
                        if (duty >= max_duty)
                        begin
                            mode     = (dir == DIR_UP) ? M_RUN_UP : M_RUN_DN;
                            run_t0   = rq.now;
                            over_cnt = '0;
                        end
                    end
                    M_RUN_UP, M_RUN_DN:
                    begin
                        if (run_age > 32'(inrush_ms) && rq.sample_ok)
                        begin
                            if (rq.sample > stall_th)
                            begin
                                if (over_cnt != 8'hFF)
                                    over_cnt++;
                            end
                            else
                            begin
                                over_cnt = '0;
                            end
                            if (over_cnt >= confirm_cnt)
                            begin
                                halt();
                                stall_hit = 1'b1;
                                over_cnt  = '0;
                            end
                        end
                    end
                    M_STOP_UP, M_STOP_DN:
                    begin
                        duty = (ramp_age >= 32'(ramp_ms)) ? 16'd0
                                                           : max_duty - ramp_share(ramp_age);
                        set_duty(duty);
                        if (duty == 16'd0)
                        begin
                            bridge_en = '0;
                            mode      = M_STOPPED;
                            dir       = DIR_NONE;
                            over_cnt  = '0;
                        end
                    end
                    default: over_cnt = '0;
                endcase
            end
            REQ_UP: start_motion(DIR_UP, rq.now);
            REQ_DN: start_motion(DIR_DN, rq.now);
            REQ_SOFT:
            begin
                if (mode == M_RAMP_UP || mode == M_RUN_UP)
                begin
                    mode    = M_STOP_UP;
                    ramp_t0 = rq.now;
                end
                else if (mode == M_RAMP_DN || mode == M_RUN_DN)
                begin
                    mode    = M_STOP_DN;
                    ramp_t0 = rq.now;
                end
            end
            REQ_HARD: halt();
            default: ;
        endcase

        st.duty_up      = up_duty;
        st.duty_down    = down_duty;
        st.enable_up    = bridge_en[0];
        st.enable_down  = bridge_en[1];
        st.motor_mode   = mode;
        st.stall_event  = stall_hit;
        st.stalled_flag = stalled;
        st.running      = (mode == M_RUN_UP || mode == M_RUN_DN);
        status_q.push_back(st);
    endfunction

    task report(string line);
        $display("MISMATCH %s", line);
        mismatches++;
    endtask

    task compare_field(string name, logic [15:0] got, logic [15:0] want);
        if (got !== want)
            report($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                             results_seen, name, got, want));
    endtask

    // Match one status word against the oldest queued expectation
    task check_result(motor_status_t got);
        motor_status_t want;
        results_seen++;
        if (status_q.size() == 0)
        begin
            report($sformatf("result %0d arrived with nothing expected", results_seen));
            return;
        end
        want = status_q.pop_front();
        compare_field("duty_up", got.duty_up, want.duty_up);
        compare_field("duty_down", got.duty_down, want.duty_down);
        compare_field("enable_up", 16'(got.enable_up), 16'(want.enable_up));
        compare_field("enable_down", 16'(got.enable_down), 16'(want.enable_down));
        compare_field("motor_mode", 16'(got.motor_mode), 16'(want.motor_mode));
        compare_field("stall_event", 16'(got.stall_event), 16'(want.stall_event));
        compare_field("stalled_flag", 16'(got.stalled_flag), 16'(want.stalled_flag));
        compare_field("running", 16'(got.running), 16'(want.running));
    endtask
endclass

module tb_motor_soft_ramp_stall_guard_core;

    // request codes the block does not define
    localparam req_t REQ_SPARE_A = 3'd5;
    localparam req_t REQ_SPARE_B = 3'd6;
    localparam req_t REQ_SPARE_C = 3'd7;

    localparam logic [11:0] SAMPLE_TOP = 12'hFFF;

    logic      clk;
    logic      rst_n;
    logic      cfg_we;
    cfg_idx_t  cfg_idx;
    cfg_data_t cfg_data;

    logic [31:0] clock_ms;
    logic        idle_on;

    motor_scoreboard sb = new();

    msrsg_in_if #(.TIME_BITS(32), .SAMPLE_BITS(12)) in_ch();
    msrsg_out_if #(.DUTY_BITS(16)) out_ch();

    motor_soft_ramp_stall_guard_core #(
        .DUTY_BITS   (16),
        .TIME_BITS   (32),
        .SAMPLE_BITS (12)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .out_ch   (out_ch),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Hold the run to a fixed ceiling
    initial
    begin
        #3_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Drive ready high, with random stall bursts while idle_on is set
    initial
    begin
        int unsigned hold;
        hold = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold != 0)
            begin
                out_ch.ready <= 1'b0;
                hold--;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                if (idle_on && $urandom_range(0, 7) == 0)
                    hold = $urandom_range(1, 11);
            end
        end
    end

    // Check every accepted status transaction
    initial
    begin
        motor_status_t got;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_ch.valid && out_ch.ready)
            begin
                got.duty_up      = out_ch.duty_up;
                got.duty_down    = out_ch.duty_down;
                got.enable_up    = out_ch.enable_up;
                got.enable_down  = out_ch.enable_down;
                got.motor_mode   = out_ch.motor_mode;
                got.stall_event  = out_ch.stall_event;
                got.stalled_flag = out_ch.stalled_flag;
                got.running      = out_ch.running;
                sb.check_result(got);
            end
        end
    end

    // Present one request, optionally after a gap, and wait until it is accepted
    task automatic send_item(req_t req, logic [31:0] t, logic [11:0] s, logic s_ok);
        motor_request_t rq;
        rq.req       = req;
        rq.now       = t;
        rq.sample    = s;
        rq.sample_ok = s_ok;
        @(negedge clk);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.req_type       <= req;
        in_ch.now_ms         <= t;
        in_ch.current_sample <= s;
        in_ch.sample_valid   <= s_ok;
        do @(posedge clk); while (!in_ch.ready);
        sb.note_request(rq);
    endtask

    // Drop valid and wait until every queued status has come back
    task automatic quiesce();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (sb.status_q.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_register(cfg_idx_t idx, cfg_data_t data);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        sb.set_register(idx, data);
    endtask

    // Load all five registers; unused upper bits of the narrow ones get noise
    task automatic apply_settings(logic [15:0] duty_full, logic [15:0] ramp,
                                  logic [15:0] inrush, logic [11:0] thr, logic [7:0] confirm);
        write_register(REG_MAX_DUTY, duty_full);
        write_register(REG_RAMP_MS, ramp);
        write_register(REG_INRUSH, inrush);
        write_register(REG_STALL_TH, {4'($urandom), thr});
        write_register(REG_CONFIRM, {8'($urandom), confirm});
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Walk the default settings through ramps, wrap, inrush, stall and stops
    task automatic run_directed();
        logic [31:0] base;
        base = 32'hFFFF_FF00;
        send_item(REQ_TICK,    32'd0,        12'd0,      1'b0);
        send_item(REQ_SPARE_A, 32'd0,        SAMPLE_TOP, 1'b1);
        send_item(REQ_SPARE_B, 32'd0,        12'd0,      1'b0);
        send_item(REQ_SPARE_C, 32'd0,        SAMPLE_TOP, 1'b1);
        send_item(REQ_SOFT,    32'd0,        12'd0,      1'b0);
        send_item(REQ_UP,      base,         12'd0,      1'b0);
        send_item(REQ_TICK,    base + 100,   SAMPLE_TOP, 1'b1);
        // repeat the move mid-ramp, then cross the time wrap
        send_item(REQ_UP,      base + 150,   12'd0,      1'b0);
        send_item(REQ_TICK,    base + 300,   12'd0,      1'b1);
        send_item(REQ_TICK,    base + 500,   12'd0,      1'b1);
        // inside inrush, then count toward a stall with a reset on equality
        send_item(REQ_TICK,    base + 700,   SAMPLE_TOP, 1'b1);
        send_item(REQ_TICK,    base + 900,   SAMPLE_TOP, 1'b1);
        send_item(REQ_TICK,    base + 950,   SAMPLE_TOP, 1'b0);
        send_item(REQ_TICK,    base + 1000,  12'd2001,   1'b1);
        send_item(REQ_TICK,    base + 1050,  12'd2000,   1'b1);
        send_item(REQ_TICK,    base + 1100,  SAMPLE_TOP, 1'b1);
        send_item(REQ_TICK,    base + 1150,  SAMPLE_TOP, 1'b1);
        send_item(REQ_TICK,    base + 1200,  SAMPLE_TOP, 1'b1);
        // down ramp, soft stop mid-ramp, restart upward, reverse, hard stop
        send_item(REQ_DN,      base + 1300,  12'd0,      1'b0);
        send_item(REQ_TICK,    base + 1550,  12'd0,      1'b1);
        send_item(REQ_SOFT,    base + 1600,  12'd0,      1'b0);
        send_item(REQ_TICK,    base + 1700,  12'd0,      1'b1);
        send_item(REQ_UP,      base + 1750,  12'd0,      1'b0);
        send_item(REQ_DN,      base + 1760,  12'd0,      1'b0);
        send_item(REQ_HARD,    32'hFFFF_FFFF, SAMPLE_TOP, 1'b1);
    endtask

    // Random requests that mostly follow the motor through its states
    task automatic run_random(int unsigned n_items);
        int unsigned done_cnt;
        int unsigned span;
        int unsigned pick;
        req_t        req;
        logic [11:0] s;
        done_cnt = 0;
        while (done_cnt < n_items)
        begin
            span = ((sb.ramp_ms > sb.inrush_ms) ? sb.ramp_ms : sb.inrush_ms) / 4 + 1;
            if ($urandom_range(0, 29) == 0)
                clock_ms = $urandom();
            else
                clock_ms = clock_ms + $urandom_range(0, span);

            // lean toward over-threshold samples so stalls get confirmed
            if (sb.stall_th != SAMPLE_TOP && $urandom_range(0, 99) < 60)
                s = 12'($urandom_range(sb.stall_th + 1, SAMPLE_TOP));
            else
                s = 12'($urandom_range(0, SAMPLE_TOP));

            pick = $urandom_range(0, 99);
            if (sb.mode == M_STOPPED && pick < 45)
                req = pick[0] ? REQ_UP : REQ_DN;
            else if (pick < 5)
                req = REQ_UP;
            else if (pick < 10)
                req = REQ_DN;
            else if (pick < 16)
                req = REQ_SOFT;
            else if (pick < 19)
                req = REQ_HARD;
            else if (pick < 21)
                req = req_t'($urandom_range(REQ_SPARE_A, REQ_SPARE_C));
            else
                req = REQ_TICK;

            send_item(req, clock_ms, s, $urandom_range(0, 9) != 0);
            if (req < REQ_SPARE_A)
            begin
                done_cnt++;
                if (done_cnt % 160 == 0)
                    quiesce();
            end
        end
    endtask

    initial
    begin
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_idx              = REG_MAX_DUTY;
        cfg_data             = '0;
        in_ch.valid          = 1'b0;
        in_ch.req_type       = REQ_TICK;
        in_ch.now_ms         = '0;
        in_ch.current_sample = '0;
        in_ch.sample_valid   = 1'b0;
        clock_ms             = '0;
        idle_on              = 1'b1;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        run_directed();
        run_random(250);

        // top of every register range
        quiesce();
        apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, SAMPLE_TOP, 8'hFF);
        run_random(150);

        // bottom of the documented ranges
        quiesce();
        apply_settings(16'd1, 16'd1, 16'd0, 12'd0, 8'd1);
        run_random(200);

        // zero ramp, zero confirm, zero duty
        quiesce();
        apply_settings(16'd0, 16'd0, 16'd0, 12'($urandom), 8'd0);
        run_random(150);

        // random settings; the last phase runs without idling
        for (int k = 0; k < 4; k++)
        begin
            quiesce();
            if (k == 3)
                idle_on = 1'b0;
            apply_settings(16'($urandom_range(1, 16'hFFFF)), 16'($urandom_range(1, 2000)),
                           16'($urandom_range(0, 500)), 12'($urandom),
                           8'($urandom_range(1, 8)));
            run_random(150);
        end

        quiesce();
        if (sb.status_q.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.status_q.size()));
        if (sb.mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
